[hw/rtl/deq_pkg.sv]
// Shared widths, codes and cell operation type for the double-ended queue.
package deq_pkg;

    localparam int KIND_W       = 3;
    localparam int VALUE_W      = 32;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 5;
    localparam int CAPACITY_DEF = 16;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READOUT    = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [2:0] {
        CELL_HOLD      = 3'd0,
        CELL_SHIFT_IN  = 3'd1,
        CELL_APPEND    = 3'd2,
        CELL_SHIFT_OUT = 3'd3,
        CELL_ROTATE    = 3'd4
    } cell_op_t;

endpackage

[hw/rtl/deq_if.sv]
// Valid/ready channel interfaces for the queue's command and result items.
interface deq_in_if;
    logic                               valid;
    logic                               ready;
    logic        [deq_pkg::KIND_W-1:0]  kind;
    logic signed [deq_pkg::VALUE_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface deq_out_if;
    logic                                valid;
    logic                                ready;
    logic        [deq_pkg::STATUS_W-1:0] status;
    logic signed [deq_pkg::VALUE_W-1:0]  data;
    logic        [deq_pkg::OCC_W-1:0]    occupancy;
    logic                                last;

    modport source (output valid, output status, output data, output occupancy,
                    output last, input ready);
    modport sink   (input valid, input status, input data, input occupancy,
                    input last, output ready);
endinterface

[hw/rtl/deq_cell.sv]
// One storage cell of the queue chain: holds a word and trades it with its neighbors.
module deq_cell #(
    parameter int CAPACITY = deq_pkg::CAPACITY_DEF,
    parameter int INDEX    = 0
) (
    input  logic                               clk,
    input  deq_pkg::cell_op_t                  op,
    input  logic [$clog2(CAPACITY+1)-1:0]      count,
    input  logic signed [deq_pkg::VALUE_W-1:0] push_value,
    input  logic signed [deq_pkg::VALUE_W-1:0] left_data,
    input  logic signed [deq_pkg::VALUE_W-1:0] right_data,
    input  logic signed [deq_pkg::VALUE_W-1:0] front_data,
    output logic signed [deq_pkg::VALUE_W-1:0] data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] IDX      = CW'(INDEX);
    localparam logic [CW-1:0] IDX_NEXT = CW'(INDEX + 1);

    logic signed [deq_pkg::VALUE_W-1:0] data_reg;
    logic signed [deq_pkg::VALUE_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (op)
            deq_pkg::CELL_SHIFT_IN:  data_next = left_data;
            deq_pkg::CELL_APPEND:
            begin
                if (count == IDX)
                begin
                    data_next = push_value;
                end
            end
            deq_pkg::CELL_SHIFT_OUT: data_next = right_data;
            deq_pkg::CELL_ROTATE:
            begin
                // the tail cell wraps the front word around
                if (count == IDX_NEXT)
                begin
                    data_next = front_data;
                end
                else
                begin
                    data_next = right_data;
                end
            end
            default:                 data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[hw/rtl/double_ended_queue.sv]
// Top level of the bounded double-ended queue built from a chain of storage cells.
//
// Bounded deque of signed 32-bit words held in a row of CAPACITY cells, with
// the front word always in cell 0 and a fill count marking the back. Push front
// shifts the whole row one cell toward the back; pop front shifts it toward the
// front; push back writes the first free cell; pop back reads the tail cell and
// drops the count. Each push or pop is accepted and yields one result item, so
// these run at one item per cycle when the result side keeps up. A readout of
// n stored words is accepted with no result and then yields the n words, one
// result item per cycle when the result side keeps up: the row rotates once per
// word, cell 0 is emitted and wrapped to the tail, so after n steps the contents
// are back in place. No new item is taken during a readout. A push on a full
// queue reports full and stores nothing; a pop or readout on an empty queue
// reports empty. Results pass through a single output register, so a new item
// is taken while the previous result is being handed off. Occupancy is the fill
// count after the operation, masked to five bits.
module double_ended_queue #(
    parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    deq_in_if.sink    in_ch,
    deq_out_if.source out_ch
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t            state_reg,  state_next;
    logic [CW-1:0]     count_reg,  count_next;
    logic [CW-1:0]     remain_reg, remain_next;

    logic                                out_valid_reg,  out_valid_next;
    logic [deq_pkg::STATUS_W-1:0]        out_status_reg, out_status_next;
    logic signed [deq_pkg::VALUE_W-1:0]  out_data_reg,   out_data_next;
    logic [deq_pkg::OCC_W-1:0]           out_occ_reg,    out_occ_next;
    logic                                out_last_reg,   out_last_next;

    deq_pkg::cell_op_t                  cell_op;
    logic signed [deq_pkg::VALUE_W-1:0] cell_data [CAPACITY];
    logic [IW-1:0]                      tail_idx;
    logic                               out_free;
    logic                               in_fire;

    // Cell row: each cell sees its neighbors, the push word and the front word
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [deq_pkg::VALUE_W-1:0] left_d;
        logic signed [deq_pkg::VALUE_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = in_ch.value;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_end
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        deq_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (i)
        ) u_cell (
            .clk        (clk),
            .op         (cell_op),
            .count      (count_reg),
            .push_value (in_ch.value),
            .left_data  (left_d),
            .right_data (right_d),
            .front_data (cell_data[0]),
            .data       (cell_data[i])
        );
    end

    // Output slot is free when empty or being taken this cycle
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE) && out_free;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign tail_idx    = IW'(count_reg - 1'b1);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        remain_next     = remain_reg;
        cell_op         = deq_pkg::CELL_HOLD;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_occ_next    = out_occ_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    // default result: single ok item with no data
                    out_valid_next  = 1'b1;
                    out_status_next = deq_pkg::STATUS_OK;
                    out_data_next   = '0;
                    out_last_next   = 1'b1;
                    case (in_ch.kind)
                        deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK:
                        begin
                            if (count_reg == FULL_COUNT)
                            begin
                                out_status_next = deq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                cell_op    = (in_ch.kind == deq_pkg::KIND_PUSH_FRONT)
                                           ? deq_pkg::CELL_SHIFT_IN : deq_pkg::CELL_APPEND;
                            end
                        end
                        deq_pkg::KIND_POP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                out_status_next = deq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                out_data_next = cell_data[0];
                                count_next    = count_reg - 1'b1;
                                cell_op       = deq_pkg::CELL_SHIFT_OUT;
                            end
                        end
                        deq_pkg::KIND_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                out_status_next = deq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                out_data_next = cell_data[tail_idx];
                                count_next    = count_reg - 1'b1;
                            end
                        end
                        deq_pkg::KIND_READOUT:
                        begin
                            if (count_reg == '0)
                            begin
                                out_status_next = deq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                // no result yet: stream the words from the next cycle
                                out_valid_next = 1'b0;
                                remain_next    = count_reg;
                                state_next     = ST_READ;
                            end
                        end
                        default:
                        begin
                            out_status_next = deq_pkg::STATUS_OK;
                        end
                    endcase
                    out_occ_next = deq_pkg::OCC_W'(count_next);
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    // emit the front word and rotate it to the back
                    out_valid_next  = 1'b1;
                    out_status_next = deq_pkg::STATUS_OK;
                    out_data_next   = cell_data[0];
                    out_occ_next    = deq_pkg::OCC_W'(count_reg);
                    out_last_next   = (remain_reg == CW'(1));
                    cell_op         = deq_pkg::CELL_ROTATE;
                    remain_next     = remain_reg - 1'b1;
                    if (remain_reg == CW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_occ_reg    <= out_occ_next;
        out_last_reg   <= out_last_next;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.status    = out_status_reg;
    assign out_ch.data      = out_data_reg;
    assign out_ch.occupancy = out_occ_reg;
    assign out_ch.last      = out_last_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("fill count above capacity");

    a_no_accept_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> !in_ch.ready)
        else $error("item accepted during readout");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (in_ch.kind == deq_pkg::KIND_PUSH_FRONT ||
                    in_ch.kind == deq_pkg::KIND_PUSH_BACK) && count_reg != FULL_COUNT
        |=> count_reg == CW'($past(count_reg) + 1'b1))
        else $error("push did not grow the fill count");

    a_read_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ && out_free && remain_reg == CW'(1)
        |=> state_reg == ST_IDLE && out_ch.valid && out_ch.last)
        else $error("readout did not close with a last item");
`endif

endmodule
